// File: hw/rtl/qte_pkg.sv
// Package for the quoted token extractor: scan mode codes, character
// constants, field widths, the result struct and the whitespace test.
// No dependencies.
package qte_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;

  localparam int START_POS_W = 16;
  localparam int END_POS_W   = 16;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 2;

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

  localparam logic [COUNT_W-1:0] EMIT_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] EMIT_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] EMIT_TWO  = 2'd2;

  typedef enum logic [1:0] {
    MODE_SKIP   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_ESCAPE = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   emit_count;
    logic [BYTE_W-1:0]    first_byte;
    logic [BYTE_W-1:0]    second_byte;
    logic                 token_done;
    logic [END_POS_W-1:0] end_position;
  } result_t;

  // Space, TAB, LF, VT, FF and CR.
  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// File: hw/rtl/qte_step.sv
// Combinational step of the token scanner: given the current scan state and
// one input transaction, computes the next state and the result.
// Depends on qte_pkg.
module qte_step #(
  parameter int POSITION_BITS = qte_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                              start_req,
  input  logic [qte_pkg::START_POS_W-1:0]   start_position,
  input  logic [qte_pkg::BYTE_W-1:0]        byte_in,
  input  logic                              last,
  input  qte_pkg::scan_mode_t               mode,
  input  logic [POSITION_BITS-1:0]          position,
  input  logic                              finished,
  output qte_pkg::scan_mode_t               mode_next,
  output logic [POSITION_BITS-1:0]          position_next,
  output logic                              finished_next,
  output qte_pkg::result_t                  result
);
  import qte_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  scan_mode_t               mode_eff;
  logic [POSITION_BITS-1:0] pos_eff;
  logic [POSITION_BITS-1:0] pos_inc;
  logic                     fin_eff;
  logic [31:0]              start_wide;
  logic [POSITION_BITS-1:0] endp;
  logic [31:0]              endp_wide;
  logic                     done;

  assign start_wide = 32'(start_position);
  assign endp_wide  = 32'(endp);

  always_comb begin
    mode_eff = start_req ? MODE_SKIP : mode;
    pos_eff  = start_req ? start_wide[POSITION_BITS-1:0] : position;
    fin_eff  = start_req ? 1'b0 : finished;
    pos_inc  = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 1'b1;

    mode_next     = mode_eff;
    position_next = pos_eff;
    finished_next = fin_eff;
    done          = 1'b0;
    endp          = '0;
    result        = '0;

    if (!fin_eff) begin
      if (byte_in == CH_NUL) begin
        done = 1'b1;
        endp = pos_eff;
      end else begin
        unique case (mode_eff)
          MODE_SKIP: begin
            if (is_blank(byte_in)) begin
              mode_next = MODE_SKIP;
            end else if (byte_in == CH_QUOTE) begin
              mode_next = MODE_QUOTED;
            end else begin
              mode_next         = MODE_PLAIN;
              result.emit_count = EMIT_ONE;
              result.first_byte = byte_in;
            end
          end
          MODE_PLAIN: begin
            if (is_blank(byte_in)) begin
              done = 1'b1;
              endp = pos_eff;
            end else begin
              result.emit_count = EMIT_ONE;
              result.first_byte = byte_in;
            end
          end
          MODE_QUOTED: begin
            if (byte_in == CH_BSLASH) begin
              mode_next = MODE_ESCAPE;
            end else if (byte_in == CH_QUOTE) begin
              done = 1'b1;
              endp = pos_eff;
            end else begin
              result.emit_count = EMIT_ONE;
              result.first_byte = byte_in;
            end
          end
          MODE_ESCAPE: begin
            mode_next = MODE_QUOTED;
            if ((byte_in == CH_QUOTE) || (byte_in == CH_BSLASH)) begin
              result.emit_count = EMIT_ONE;
              result.first_byte = byte_in;
            end else begin
              result.emit_count  = EMIT_TWO;
              result.first_byte  = CH_BSLASH;
              result.second_byte = byte_in;
            end
          end
          default: begin
            mode_next = MODE_SKIP;
          end
        endcase
        // Last byte of the string ends the scan one past its position.
        if (!done && last) begin
          done = 1'b1;
          endp = pos_inc;
        end
      end
      if (done) begin
        finished_next = 1'b1;
      end else begin
        position_next = pos_inc;
      end
    end

    result.token_done   = done;
    result.end_position = endp_wide[END_POS_W-1:0];
  end

endmodule

// File: hw/rtl/quoted_token_extractor_unit.sv
// Top level of the quoted token extractor: input register, scan state,
// result register and stream handshakes.
// Depends on qte_pkg and qte_step.

// The unit takes one character per transaction on the slave stream and
// returns exactly one result transaction per input, in order. A start flag in
// s_tuser opens a scan at the given position; leading whitespace is skipped,
// a plain token ends at whitespace, a quoted token ends at the closing quote,
// and inside quotes backslash escapes emit one or two bytes. The result
// carries the emitted bytes and, on the transaction that ends the scan,
// m_tlast with the end position. Throughput is one transaction per clock
// cycle while the result side does not stall. A transaction is registered
// first in the input register and then in the result register, where
// m_tvalid rises and the result can be taken. The scan state update is a
// single small mode machine evaluated between those two registers, so a
// new character is taken every cycle as long as the result register is
// empty or being taken; while a result waits downstream, the input holds.
module quoted_token_extractor_unit #(
  parameter int POSITION_BITS = qte_pkg::POSITION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] start_position, [23:16] byte_in
  input  logic [0:0]  s_tuser,   // [0] start_req
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [1:0] emit_count, [9:2] first_byte,
                                 // [17:10] second_byte, [33:18] end_position,
                                 // [39:34] zero
  output logic        m_tlast    // token_done
);
  import qte_pkg::*;

  // Input register.
  logic                   in_valid;
  logic                   in_start;
  logic [START_POS_W-1:0] in_pos;
  logic [BYTE_W-1:0]      in_byte;
  logic                   in_last;

  // Scan state, updated when a transaction moves into the result register.
  scan_mode_t               mode;
  logic [POSITION_BITS-1:0] position;
  logic                     finished;

  scan_mode_t               mode_next;
  logic [POSITION_BITS-1:0] position_next;
  logic                     finished_next;

  // Result register.
  logic    out_valid;
  result_t out_res;
  result_t res;

  logic advance;

  // The input register drains whenever the result register is empty or is
  // being taken in this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  qte_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .start_req      (in_start),
    .start_position (in_pos),
    .byte_in        (in_byte),
    .last           (in_last),
    .mode           (mode),
    .position       (position),
    .finished       (finished),
    .mode_next      (mode_next),
    .position_next  (position_next),
    .finished_next  (finished_next),
    .result         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      mode      <= MODE_SKIP;
      position  <= '0;
      finished  <= 1'b1;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        mode      <= mode_next;
        position  <= position_next;
        finished  <= finished_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_start <= s_tuser[0];
      in_pos   <= s_tdata[15:0];
      in_byte  <= s_tdata[23:16];
      in_last  <= s_tlast;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.token_done;
  assign m_tdata  = {6'b0, out_res.end_position, out_res.second_byte,
                     out_res.first_byte, out_res.emit_count};

  // At most two bytes are ever emitted per transaction.
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("emit_count out of range");

  // End position is reported only with the done flag.
  a_endp_only_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[33:18] == '0))
    else $error("end_position set without token_done");

  // A two-byte escape always leads with the backslash.
  a_escape_pair: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] == EMIT_TWO)) |-> (m_tdata[9:2] == CH_BSLASH))
    else $error("two-byte emit without leading backslash");

  // Ending a scan leaves the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && res.token_done) |=> finished)
    else $error("scan ended but block not idle");

  // With an empty result register the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule
